FILE: design/pxu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pxu_pkg;

  localparam int VP_BITS       = 12;
  localparam int SZ_BITS       = 13;
  localparam int ROW_BITS      = 64;
  localparam int ENTRY_BITS    = 16;
  localparam int VEC_BITS      = 16;
  localparam int ACC_BITS      = 34;
  localparam int MAG_BITS      = 33;
  localparam int WNUM_BITS     = MAG_BITS + 16;
  localparam int WORLD_BITS    = 32;
  localparam int CFG_IDX_BITS  = 4;
  localparam int CFG_DATA_BITS = 64;

  localparam int Q14_ONE = 16384;
  localparam int Q14_MIN = -32768;
  localparam int Q14_MAX = 32767;

  localparam logic [CFG_IDX_BITS-1:0] REG_VP_X    = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_VP_Y    = 4'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_VP_W    = 4'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_VP_H    = 4'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAT_R0  = 4'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAT_R1  = 4'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAT_R2  = 4'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAT_R3  = 4'd7;

  localparam logic [SZ_BITS-1:0]  VP_W_RESET = 13'd640;
  localparam logic [SZ_BITS-1:0]  VP_H_RESET = 13'd480;
  localparam logic [ROW_BITS-1:0] ROW0_RESET = 64'h0000_0000_0000_1000;
  localparam logic [ROW_BITS-1:0] ROW1_RESET = 64'h0000_0000_1000_0000;
  localparam logic [ROW_BITS-1:0] ROW2_RESET = 64'h0000_1000_0000_0000;
  localparam logic [ROW_BITS-1:0] ROW3_RESET = 64'h1000_0000_0000_0000;

  typedef logic [3:0][ROW_BITS-1:0] matrix_t;
  typedef logic signed [ACC_BITS-1:0] acc_t;
  typedef logic signed [VEC_BITS-1:0] vec_t;

endpackage

`default_nettype wire

FILE: design/pixel_unproject.sv
`timescale 1ns / 1ps
`default_nettype none
// structure: restoring divider pipelines of one quotient bit per stage, a pair for the
// viewport normalisation and a set of three for the perspective divide
// throughput: one word per cycle; all stages hold together while the output
// register is full and not taken
// reset: config registers return to a scaled identity matrix (0x1000 on the diagonal) and a 640x480 viewport at 0,0

module pixel_unproject
  import pxu_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [COORD_BITS-1:0]    pixel_x_i,
  input  wire logic [COORD_BITS-1:0]    pixel_y_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic signed [WORLD_BITS-1:0]  world_x_o,
  output logic signed [WORLD_BITS-1:0]  world_y_o,
  output logic signed [WORLD_BITS-1:0]  world_z_o,
  output logic                          point_valid_o
);

  localparam int DFW = ((COORD_BITS > VP_BITS) ? COORD_BITS : VP_BITS) + 1;
  localparam int NNW = DFW + 14;

  logic [VP_BITS-1:0] vp_x_q, vp_y_q;
  logic [SZ_BITS-1:0] vp_w_q, vp_h_q;
  matrix_t            mat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_x_q <= '0;
      vp_y_q <= '0;
      vp_w_q <= VP_W_RESET;
      vp_h_q <= VP_H_RESET;
      mat_q  <= {ROW3_RESET, ROW2_RESET, ROW1_RESET, ROW0_RESET};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_VP_X:   vp_x_q   <= cfg_data_i[VP_BITS-1:0];
        REG_VP_Y:   vp_y_q   <= cfg_data_i[VP_BITS-1:0];
        REG_VP_W:   vp_w_q   <= cfg_data_i[SZ_BITS-1:0];
        REG_VP_H:   vp_h_q   <= cfg_data_i[SZ_BITS-1:0];
        REG_MAT_R0: mat_q[0] <= cfg_data_i;
        REG_MAT_R1: mat_q[1] <= cfg_data_i;
        REG_MAT_R2: mat_q[2] <= cfg_data_i;
        REG_MAT_R3: mat_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // viewport offset, magnitude scaled by two in Q.14
  logic signed [DFW-1:0] dx, dy;
  logic [DFW-2:0]        ax, ay;
  logic [SZ_BITS-1:0]    sx, sy;

  always_comb begin
    dx = $signed({{(DFW-COORD_BITS){1'b0}}, pixel_x_i})
       - $signed({{(DFW-VP_BITS){1'b0}}, vp_x_q});
    dy = $signed({{(DFW-COORD_BITS){1'b0}}, pixel_y_i})
       - $signed({{(DFW-VP_BITS){1'b0}}, vp_y_q});
    ax = dx[DFW-1] ? (DFW-1)'(-dx) : (DFW-1)'(dx);
    ay = dy[DFW-1] ? (DFW-1)'(-dy) : (DFW-1)'(dy);
    sx = (vp_w_q == '0) ? SZ_BITS'(1) : vp_w_q;
    sy = (vp_h_q == '0) ? SZ_BITS'(1) : vp_h_q;
  end

  logic           nv, nvy;
  logic [NNW-1:0] qx, qy;
  logic           nsx, nsy;

  pxu_udiv #(.NW(NNW), .DW(SZ_BITS), .SW(1)) u_div_nx (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(in_valid_i), .num_i({ax, 15'b0}), .dvs_i(sx), .side_i(dx[DFW-1]),
    .valid_o(nv), .quo_o(qx), .side_o(nsx)
  );

  pxu_udiv #(.NW(NNW), .DW(SZ_BITS), .SW(1)) u_div_ny (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(in_valid_i), .num_i({ay, 15'b0}), .dvs_i(sy), .side_i(dy[DFW-1]),
    .valid_o(nvy), .quo_o(qy), .side_o(nsy)
  );

  logic signed [NNW+1:0] tx, ty;
  vec_t                  nx_q, ny_q;
  logic                  nv_q;

  always_comb begin
    tx = (NNW+2)'((nsx ? -$signed({2'b0, qx}) : $signed({2'b0, qx})) - Q14_ONE);
    ty = (NNW+2)'((nsy ? -$signed({2'b0, qy}) : $signed({2'b0, qy})) - Q14_ONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_q <= 1'b0;
    end else if (en) begin
      nv_q <= nv && nvy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_q <= (tx < Q14_MIN) ? VEC_BITS'(Q14_MIN) :
              (tx > Q14_MAX) ? VEC_BITS'(Q14_MAX) : tx[VEC_BITS-1:0];
      ny_q <= (ty < Q14_MIN) ? VEC_BITS'(Q14_MIN) :
              (ty > Q14_MAX) ? VEC_BITS'(Q14_MAX) : ty[VEC_BITS-1:0];
    end
  end

  logic mv;
  acc_t acc [4];

  pxu_matvec u_matvec (
    .clk_i, .rst_ni, .en_i(en), .valid_i(nv_q),
    .nx_i(nx_q), .ny_i(ny_q), .mat_i(mat_q),
    .valid_o(mv), .acc_o(acc)
  );

  // sign-magnitude split for the perspective divide
  logic [ACC_BITS-1:0] aw;
  logic                wz;
  assign aw = acc[3][ACC_BITS-1] ? ACC_BITS'(-acc[3]) : ACC_BITS'(acc[3]);
  assign wz = (acc[3] == '0);

  logic                 wv [3];
  logic [WNUM_BITS-1:0] wq [3];
  logic [1:0]           ws [3];

  for (genvar r = 0; r < 3; r++) begin : g_wdiv
    logic [ACC_BITS-1:0] am;
    assign am = acc[r][ACC_BITS-1] ? ACC_BITS'(-acc[r]) : ACC_BITS'(acc[r]);

    pxu_udiv #(.NW(WNUM_BITS), .DW(MAG_BITS), .SW(2)) u_div_w (
      .clk_i, .rst_ni, .en_i(en), .valid_i(mv),
      .num_i({am[MAG_BITS-1:0], 16'b0}), .dvs_i(aw[MAG_BITS-1:0]),
      .side_i({acc[r][ACC_BITS-1] ^ acc[3][ACC_BITS-1], wz}),
      .valid_o(wv[r]), .quo_o(wq[r]), .side_o(ws[r])
    );
  end

  logic signed [WORLD_BITS-1:0] res [3];

  for (genvar r = 0; r < 3; r++) begin : g_sat
    logic big;
    assign big = (wq[r][WNUM_BITS-1:WORLD_BITS-1] != '0);
    always_comb begin
      if (ws[r][0]) begin
        res[r] = '0;
      end else if (ws[r][1]) begin
        res[r] = big ? {1'b1, {(WORLD_BITS-1){1'b0}}} : -wq[r][WORLD_BITS-1:0];
      end else begin
        res[r] = big ? {1'b0, {(WORLD_BITS-1){1'b1}}} : wq[r][WORLD_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= wv[0] && wv[1] && wv[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      world_x_o     <= res[0];
      world_y_o     <= res[1];
      world_z_o     <= res[2];
      point_valid_o <= !ws[0][0];
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: design/pxu_udiv.sv
`timescale 1ns / 1ps
`default_nettype none

module pxu_udiv #(
  parameter int NW = 27,
  parameter int DW = 13,
  parameter int SW = 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] dvs_i,
  input  wire logic [SW-1:0] side_i,
  output logic               valid_o,
  output logic [NW-1:0]      quo_o,
  output logic [SW-1:0]      side_o
);

  logic          v_q  [NW+1];
  logic [NW-1:0] nq_q [NW+1];
  logic [DW-1:0] d_q  [NW+1];
  logic [DW-1:0] r_q  [NW+1];
  logic [SW-1:0] s_q  [NW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nq_q[0] <= num_i;
      d_q[0]  <= dvs_i;
      r_q[0]  <= '0;
      s_q[0]  <= side_i;
    end
  end

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          take;

    always_comb begin
      trial = {r_q[k], nq_q[k][NW-1]};
      diff  = trial - {1'b0, d_q[k]};
      take  = (trial >= {1'b0, d_q[k]});
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nq_q[k+1] <= {nq_q[k][NW-2:0], take};
        d_q[k+1]  <= d_q[k];
        r_q[k+1]  <= take ? diff[DW-1:0] : trial[DW-1:0];
        s_q[k+1]  <= s_q[k];
      end
    end
  end

  assign valid_o = v_q[NW];
  assign quo_o   = nq_q[NW];
  assign side_o  = s_q[NW];

endmodule

`default_nettype wire

FILE: design/pxu_matvec.sv
`timescale 1ns / 1ps
`default_nettype none

module pxu_matvec
  import pxu_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    en_i,
  input  wire logic    valid_i,
  input  wire vec_t    nx_i,
  input  wire vec_t    ny_i,
  input  wire matrix_t mat_i,
  output logic         valid_o,
  output acc_t         acc_o [4]
);

  logic signed [2*VEC_BITS-1:0] px_q [4];
  logic signed [2*VEC_BITS-1:0] py_q [4];
  logic signed [ENTRY_BITS:0]   s_q  [4];
  logic                         v1_q;
  logic                         v2_q;
  acc_t                         acc_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  for (genvar r = 0; r < 4; r++) begin : g_row
    logic signed [ENTRY_BITS-1:0] e0, e1, e2, e3;
    assign e0 = $signed(mat_i[r][0*ENTRY_BITS +: ENTRY_BITS]);
    assign e1 = $signed(mat_i[r][1*ENTRY_BITS +: ENTRY_BITS]);
    assign e2 = $signed(mat_i[r][2*ENTRY_BITS +: ENTRY_BITS]);
    assign e3 = $signed(mat_i[r][3*ENTRY_BITS +: ENTRY_BITS]);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        px_q[r] <= e0 * nx_i;
        py_q[r] <= e1 * ny_i;
        // z and w inputs are one, so those columns only add
        s_q[r]  <= {e2[ENTRY_BITS-1], e2} + {e3[ENTRY_BITS-1], e3};
        acc_q[r] <= ACC_BITS'(px_q[r]) + ACC_BITS'(py_q[r])
                  + (ACC_BITS'(s_q[r]) <<< 14);
      end
    end
    assign acc_o[r] = acc_q[r];
  end

  assign valid_o = v2_q;

endmodule

`default_nettype wire

FILE: test/tb_pixel_unproject.sv
`timescale 1ns / 1ps

module tb_pixel_unproject;
  import pxu_pkg::*;

  localparam int COORD_BITS  = 12;
  localparam int LATENCY     = COORD_BITS + 69;
  localparam int STALL_LIMIT = 5000;
  localparam int N_RANDOM    = 900;

  typedef struct {
    logic signed [31:0] wx;
    logic signed [31:0] wy;
    logic signed [31:0] wz;
    logic               pv;
  } point_t;

  typedef struct {
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    logic                  known;
    point_t                pt;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i = REG_VP_X;
  logic [CFG_DATA_BITS-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [COORD_BITS-1:0] pixel_x_i = '0;
  logic [COORD_BITS-1:0] pixel_y_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [WORLD_BITS-1:0] world_x_o, world_y_o, world_z_o;
  logic point_valid_o;

  pixel_unproject #(.COORD_BITS(COORD_BITS)) u_dut (.*);

  always #4 clk_i = ~clk_i;

  // local copy of the register file
  logic [11:0] vp_x, vp_y;
  logic [12:0] vp_w, vp_h;
  logic [63:0] mat_row [4];

  point_t expected_points [$];
  int     n_errors = 0;
  int     idle_cycles = 0;
  bit     hold_long = 1'b0;
  bit     drain_done = 1'b0;

  function automatic longint norm_coord(longint pix, longint org, longint sz);
    longint q;
    if (sz == 0) sz = 1;
    q = ((pix - org) * 2 * Q14_ONE) / sz - Q14_ONE;
    if (q < Q14_MIN) q = Q14_MIN;
    if (q > Q14_MAX) q = Q14_MAX;
    return q;
  endfunction

  function automatic point_t unproject(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py);
    longint v [4];
    longint acc [4];
    longint q;
    point_t p;
    v[0] = norm_coord(longint'(px), longint'(vp_x), longint'(vp_w));
    v[1] = norm_coord(longint'(py), longint'(vp_y), longint'(vp_h));
    v[2] = Q14_ONE;
    v[3] = Q14_ONE;
    for (int r = 0; r < 4; r++) begin
      acc[r] = 0;
      for (int c = 0; c < 4; c++) begin
        acc[r] += longint'($signed(mat_row[r][16*c +: 16])) * v[c];
      end
    end
    p = '{0, 0, 0, 1'b0};
    if (acc[3] != 0) begin
      p.pv = 1'b1;
      for (int r = 0; r < 3; r++) begin
        q = (acc[r] * 65536) / acc[3];
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (r == 0) p.wx = q[31:0];
        else if (r == 1) p.wy = q[31:0];
        else p.wz = q[31:0];
      end
    end
    return p;
  endfunction

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [63:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_VP_X:   vp_x = data[11:0];
      REG_VP_Y:   vp_y = data[11:0];
      REG_VP_W:   vp_w = data[12:0];
      REG_VP_H:   vp_h = data[12:0];
      REG_MAT_R0: mat_row[0] = data;
      REG_MAT_R1: mat_row[1] = data;
      REG_MAT_R2: mat_row[2] = data;
      REG_MAT_R3: mat_row[3] = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_word(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py,
                           logic known, point_t pt);
    int gap;
    gap = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) in_valid_i <= 1'b0;
    repeat (gap) @(negedge clk_i);
    in_valid_i <= 1'b1;
    pixel_x_i <= px;
    pixel_y_i <= py;
    do @(posedge clk_i); while (!in_ready_o);
    expected_points.push_back(known ? pt : unproject(px, py));
    @(negedge clk_i);
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand_row();
    logic [63:0] r;
    for (int c = 0; c < 4; c++) begin
      case ($urandom_range(0, 5))
        0: r[16*c +: 16] = 16'h8000;
        1: r[16*c +: 16] = 16'h7fff;
        2: r[16*c +: 16] = 16'h0000;
        default: r[16*c +: 16] = 16'($urandom_range(0, 16'hffff));
      endcase
    end
    return r;
  endfunction

  // receiver: random stalls, plus one long hold-off
  always begin
    int gap;
    @(negedge clk_i);
    if (hold_long) begin
      out_ready_i <= 1'b0;
      repeat (400) @(negedge clk_i);
      hold_long = 1'b0;
    end
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
    if (gap > 0) out_ready_i <= 1'b0;
    repeat (gap) @(negedge clk_i);
    out_ready_i <= 1'b1;
    do @(posedge clk_i); while (!out_valid_o);
  end

  always @(posedge clk_i) begin
    point_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_points.size() == 0) begin
        $error("word with nothing expected");
        n_errors++;
      end else begin
        e = expected_points.pop_front();
        if (world_x_o !== e.wx) begin
          $error("world_x expected %0d actual %0d", e.wx, world_x_o);
          n_errors++;
        end
        if (world_y_o !== e.wy) begin
          $error("world_y expected %0d actual %0d", e.wy, world_y_o);
          n_errors++;
        end
        if (world_z_o !== e.wz) begin
          $error("world_z expected %0d actual %0d", e.wz, world_z_o);
          n_errors++;
        end
        if (point_valid_o !== e.pv) begin
          $error("point_valid expected %0b actual %0b", e.pv, point_valid_o);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || drain_done ||
        (expected_points.size() == 0 && !in_valid_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  stim_row_t directed [9] = '{
    '{12'd0,    12'd0,    1'b1, '{-32'sd65536, -32'sd65536, 32'sd65536, 1'b1}},
    '{12'd320,  12'd240,  1'b1, '{32'sd0, 32'sd0, 32'sd65536, 1'b1}},
    '{12'd640,  12'd480,  1'b1, '{32'sd65536, 32'sd65536, 32'sd65536, 1'b1}},
    '{12'd4095, 12'd4095, 1'b1, '{32'sd131068, 32'sd131068, 32'sd65536, 1'b1}},
    '{12'd0,    12'd4095, 1'b0, '{0, 0, 0, 1'b0}},
    '{12'd4095, 12'd0,    1'b0, '{0, 0, 0, 1'b0}},
    '{12'd639,  12'd479,  1'b0, '{0, 0, 0, 1'b0}},
    '{12'hAAA,  12'h555,  1'b0, '{0, 0, 0, 1'b0}},
    '{12'h555,  12'hAAA,  1'b0, '{0, 0, 0, 1'b0}}
  };

  initial begin
    logic [63:0] d;
    vp_x = '0; vp_y = '0; vp_w = VP_W_RESET; vp_h = VP_H_RESET;
    mat_row[0] = ROW0_RESET; mat_row[1] = ROW1_RESET;
    mat_row[2] = ROW2_RESET; mat_row[3] = ROW3_RESET;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) send_word(directed[i].px, directed[i].py, directed[i].known,
                                    directed[i].pt);
    wait_drain();

    // zero w: bottom row all zero
    write_reg(REG_MAT_R3, 64'h0);
    send_word(12'd100, 12'd100, 1'b1, '{0, 0, 0, 1'b0});
    send_word(12'd4095, 12'd0, 1'b1, '{0, 0, 0, 1'b0});
    wait_drain();

    // zero sizes, wide data, ignored index, extreme matrix
    write_reg(REG_VP_W, 64'hFFFF_FFFF_FFFF_E000);
    write_reg(REG_VP_H, 64'h0);
    write_reg(REG_VP_X, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_VP_Y, 64'h0);
    write_reg(4'd9, 64'h1234);
    write_reg(4'd15, 64'h0);
    write_reg(REG_MAT_R0, 64'h7fff_7fff_7fff_7fff);
    write_reg(REG_MAT_R1, 64'h8000_8000_8000_8000);
    write_reg(REG_MAT_R2, 64'h7fff_8000_0001_ffff);
    write_reg(REG_MAT_R3, 64'h0001_0000_0000_0000);
    send_word(12'd0, 12'd0, 1'b0, '{0, 0, 0, 1'b0});
    send_word(12'd4095, 12'd4095, 1'b0, '{0, 0, 0, 1'b0});
    send_word(12'd2048, 12'd1, 1'b0, '{0, 0, 0, 1'b0});
    wait_drain();

    write_reg(REG_VP_W, 64'd4096);
    write_reg(REG_VP_H, 64'd1);
    write_reg(REG_VP_X, 64'd4095);
    send_word(12'd4095, 12'd0, 1'b0, '{0, 0, 0, 1'b0});
    send_word(12'd0, 12'd4095, 1'b0, '{0, 0, 0, 1'b0});
    wait_drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_VP_X, (ph % 2) ? 64'($urandom_range(0, 4095))
                                   : 64'($urandom_range(0, 64)));
      write_reg(REG_VP_Y, (ph % 2) ? 64'($urandom_range(0, 4095))
                                   : 64'($urandom_range(0, 64)));
      write_reg(REG_VP_W, (ph == 5) ? 64'd4096 : 64'($urandom_range(1, 4096)));
      write_reg(REG_VP_H, (ph == 4) ? 64'd1 : 64'($urandom_range(1, 4096)));
      for (int r = 0; r < 4; r++) begin
        d = (ph == 0) ? {$urandom(), $urandom()} : rand_row();
        if (r == 3 && ph == 3) d[63:48] = 16'h0;
        write_reg(CFG_IDX_BITS'(REG_MAT_R0 + r), d);
      end
      if (ph == 2) hold_long = 1'b1;
      for (int i = 0; i < N_RANDOM / 6; i++) begin
        send_word(COORD_BITS'($urandom_range(0, 4095)),
                  COORD_BITS'($urandom_range(0, 4095)), 1'b0,
                  '{0, 0, 0, 1'b0});
      end
      wait_drain();
    end

    drain_done = 1'b1;
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/pxu_pkg.sv
design/pxu_udiv.sv
design/pxu_matvec.sv
design/pixel_unproject.sv
test/tb_pixel_unproject.sv
